/* rtl/veh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package veh_pkg;

    // Longest encoding: five ID bytes, one size byte and four value bytes.
    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned ID_BYTES    = 5;
    localparam int unsigned TAIL_BYTES  = 5;

    localparam logic [1:0] REQ_UINT8  = 2'd0;
    localparam logic [1:0] REQ_UINT16 = 2'd1;
    localparam logic [1:0] REQ_UINT32 = 2'd2;
    localparam logic [1:0] REQ_DATA   = 2'd3;

    // Size field bytes for the fixed-width unsigned elements.
    localparam logic [7:0] SIZE_UINT8  = 8'h81;
    localparam logic [7:0] SIZE_UINT16 = 8'h82;
    localparam logic [7:0] SIZE_UINT32 = 8'h84;
    // Marker nibble of the four-byte size field (bit 28 of the field).
    localparam logic [3:0] SIZE4_MARK  = 4'h1;

    // Byte FRAME_BYTES-1 goes out first.
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
    } t_frame;

endpackage

`default_nettype wire

/* rtl/veh_frame_build.sv */
`timescale 1ns / 1ps
`default_nettype none

module veh_frame_build (
    input  logic [1:0]      i_req_type,
    input  logic [31:0]     i_elem_id,
    input  logic [31:0]     i_value,
    input  logic [27:0]     i_payload_len,
    output veh_pkg::t_frame o_frame
);
    import veh_pkg::*;

    logic [2:0]                       id_len;
    logic [39:0]                      id_word;
    logic [39:0]                      id_left;
    logic [TAIL_BYTES-1:0][7:0]       tail;
    logic [2:0]                       tail_len;
    logic [3:0]                       rel;

    // The ID length is the smallest n with id <= 2^(7n)-2.
    always_comb begin
        if (i_elem_id <= 32'd126) begin
            id_len = 3'd1;
        end else if (i_elem_id <= 32'd16382) begin
            id_len = 3'd2;
        end else if (i_elem_id <= 32'd2097150) begin
            id_len = 3'd3;
        end else if (i_elem_id <= 32'd268435454) begin
            id_len = 3'd4;
        end else begin
            id_len = 3'd5;
        end
    end

    always_comb begin
        id_word = {8'h00, i_elem_id};
        case (id_len)
            3'd1:    id_word[7]  = 1'b1;
            3'd2:    id_word[14] = 1'b1;
            3'd3:    id_word[21] = 1'b1;
            3'd4:    id_word[28] = 1'b1;
            default: id_word[35] = 1'b1;
        endcase
        // Left-align so the first ID byte sits in the top byte.
        id_left = id_word << ({3'd0, 3'(3'd5 - id_len)} * 6'd8);
    end

    // Everything after the ID: size field and value, first byte in slot 4.
    always_comb begin
        tail = '0;
        case (i_req_type)
            REQ_UINT8: begin
                tail[4]  = SIZE_UINT8;
                tail[3]  = i_value[7:0];
                tail_len = 3'd2;
            end
            REQ_UINT16: begin
                tail[4]  = SIZE_UINT16;
                tail[3]  = i_value[15:8];
                tail[2]  = i_value[7:0];
                tail_len = 3'd3;
            end
            REQ_UINT32: begin
                tail[4]  = SIZE_UINT32;
                tail[3]  = i_value[31:24];
                tail[2]  = i_value[23:16];
                tail[1]  = i_value[15:8];
                tail[0]  = i_value[7:0];
                tail_len = 3'd5;
            end
            REQ_DATA: begin
                tail[4]  = {SIZE4_MARK, i_payload_len[27:24]};
                tail[3]  = i_payload_len[23:16];
                tail[2]  = i_payload_len[15:8];
                tail[1]  = i_payload_len[7:0];
                tail_len = 3'd4;
            end
            default: begin
                tail_len = 3'd4;
            end
        endcase
    end

    always_comb begin
        o_frame.bytes = '0;
        rel           = '0;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (4'(k) < {1'b0, id_len}) begin
                o_frame.bytes[FRAME_BYTES-1-k] = id_left[39-8*k -: 8];
            end else begin
                rel = 4'(k) - {1'b0, id_len};
                if (rel < {1'b0, tail_len}) begin
                    o_frame.bytes[FRAME_BYTES-1-k] = tail[3'(3'd4 - rel[2:0])];
                end
            end
        end
        o_frame.count = {1'b0, id_len} + {1'b0, tail_len};
    end

endmodule

`default_nettype wire

/* rtl/veh_serializer.sv */
`timescale 1ns / 1ps
`default_nettype none

module veh_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  veh_pkg::t_frame i_frame,
    output logic            o_can_load,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);
    import veh_pkg::*;

    logic [FRAME_BYTES-1:0][7:0] r_bytes;
    logic [FRAME_BYTES-1:0][7:0] n_bytes;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            n_cnt;
    logic                        beat;

    assign o_valid    = (r_cnt != '0);
    assign o_byte     = r_bytes[FRAME_BYTES-1];
    assign o_last     = (r_cnt == CNT_W'(1));
    assign beat       = o_valid && i_ready;
    // A new frame may enter as the final byte of the current one leaves.
    assign o_can_load = !o_valid || (o_last && i_ready);

    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        if (i_load) begin
            n_bytes = i_frame.bytes;
            n_cnt   = i_frame.count;
        end else if (beat) begin
            n_bytes = {r_bytes[FRAME_BYTES-2:0], 8'h00};
            n_cnt   = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* rtl/vint_element_header_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (low bit up)                                   tuser      tlast
// s_axis    in   elem_id[31:0], value[63:32], payload_len[91:64], pad  req_type   -
// m_axis    out  out_byte[7:0]                                        -          last byte
//
// Each request gives 3 to 10 output beats, one byte per cycle while m_axis_tready
// is high, so the request rate is set by the byte serializer.
// A request goes input register -> encoder -> byte buffer; the next request
// waits in the input register and moves up as the last byte is taken.
// Reset is synchronous and active low and empties both stages at once.
module vint_element_header_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // elem_id, value, payload_len, zero pad
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte
    output logic        m_axis_tlast
);
    import veh_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_req_type;
    logic [31:0] r_elem_id;
    logic [31:0] r_value;
    logic [27:0] r_payload_len;
    logic        can_load;
    logic        load;
    t_frame      frame;

    assign load          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req_type    <= s_axis_tuser;
            r_elem_id     <= s_axis_tdata[31:0];
            r_value       <= s_axis_tdata[63:32];
            r_payload_len <= s_axis_tdata[91:64];
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    veh_frame_build u_build (
        .i_req_type    (r_req_type),
        .i_elem_id     (r_elem_id),
        .i_value       (r_value),
        .i_payload_len (r_payload_len),
        .o_frame       (frame)
    );

    veh_serializer u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_frame    (frame),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> m_axis_tvalid)
        else $error("loaded frame did not appear on the output");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && m_axis_tready && !load) |=> !m_axis_tvalid)
        else $error("output still valid after final beat");

    a_hold_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !load) |=> r_in_valid)
        else $error("pending request dropped");

endmodule

`default_nettype wire

/* tb/sv/veh_encoding_checker.sv */
`timescale 1ns / 1ps

module veh_encoding_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,  // elem_id, value, payload_len, zero pad
    input  logic [1:0]  i_s_axis_tuser,  // req_type
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  i_m_axis_tdata,  // out_byte
    input  logic        i_m_axis_tlast,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_requests,
    output int          o_bytes
);
    import veh_pkg::*;

    localparam int unsigned MAX_REPORTS = 10;
    // Marker bit of the four-byte size field in a data header.
    localparam logic [63:0] DATA_SIZE_MARK = 64'h0000_0000_1000_0000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    t_enc_byte expected_bytes[$];
    int        mismatch_cnt = 0;
    int        request_cnt  = 0;
    int        byte_cnt     = 0;

    // Queue the low bytes of a word, most significant first.
    function automatic void queue_bytes(logic [63:0] word, int count, bit ends_element);
        t_enc_byte b;
        for (int k = 0; k < count; k++) begin
            b.data = word[(count - 1 - k) * 8 +: 8];
            b.last = ends_element && (k == count - 1);
            expected_bytes.push_back(b);
        end
    endfunction

    function automatic void predict_encoding(logic [1:0] kind, logic [31:0] elem_id,
                                             logic [31:0] value, logic [27:0] payload_len);
        int          id_len;
        int          width;
        logic [7:0]  size_byte;
        logic [63:0] id_wide;
        id_wide = {32'd0, elem_id};
        id_len  = 1;
        // The all-ones pattern of each length is reserved, hence the minus two.
        while (id_len < ID_BYTES && id_wide > (64'd1 << (7 * id_len)) - 64'd2)
            id_len++;
        queue_bytes(id_wide | (64'd1 << (7 * id_len)), id_len, 1'b0);
        if (kind == REQ_DATA) begin
            queue_bytes({36'd0, payload_len} | DATA_SIZE_MARK, 4, 1'b1);
        end else begin
            case (kind)
                REQ_UINT8: begin
                    width     = 1;
                    size_byte = SIZE_UINT8;
                end
                REQ_UINT16: begin
                    width     = 2;
                    size_byte = SIZE_UINT16;
                end
                default: begin
                    width     = 4;
                    size_byte = SIZE_UINT32;
                end
            endcase
            queue_bytes({56'd0, size_byte}, 1, 1'b0);
            queue_bytes({32'd0, value}, width, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_enc_byte want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_encoding(i_s_axis_tuser, i_s_axis_tdata[31:0],
                                 i_s_axis_tdata[63:32], i_s_axis_tdata[91:64]);
                request_cnt++;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                byte_cnt++;
                if (expected_bytes.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected beat %02h last %0b", $realtime,
                                 i_m_axis_tdata, i_m_axis_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.data !== i_m_axis_tdata || want.last !== i_m_axis_tlast) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("%0t: beat %0d expected %02h last %0b, got %02h last %0b",
                                     $realtime, byte_cnt, want.data, want.last,
                                     i_m_axis_tdata, i_m_axis_tlast);
                    end
                end
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_bytes.size();
        o_requests   <= request_cnt;
        o_bytes      <= byte_cnt;
    end

endmodule

/* tb/sv/vint_element_header_encoder_tb.sv */
`timescale 1ns / 1ps

module vint_element_header_encoder_tb;
    import veh_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 370;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;  // elem_id, value, payload_len, zero pad
    logic [1:0]  s_axis_tuser;  // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;  // out_byte
    logic        m_axis_tlast;

    int mismatches;
    int pending;
    int requests;
    int bytes_seen;
    int cycle_cnt = 0;

    bit sender_idles = 1'b1;
    bit hold_off_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vint_element_header_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    veh_encoding_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_requests      (requests),
        .o_bytes         (bytes_seen)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Element IDs cluster on the length boundaries, where the encoder switches widths.
    function automatic logic [31:0] pick_elem_id();
        int          id_len;
        logic [63:0] lo;
        logic [63:0] hi;
        int          r;
        id_len = $urandom_range(1, 5);
        lo = (id_len == 1) ? 64'd0 : (64'd1 << (7 * (id_len - 1))) - 64'd1;
        hi = (id_len == 5) ? 64'hffff_ffff : (64'd1 << (7 * id_len)) - 64'd2;
        r  = $urandom_range(0, 3);
        if (r == 0)
            return hi[31:0];
        else if (r == 1)
            return lo[31:0];
        else
            return $urandom_range(hi[31:0], lo[31:0]);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        else if (r == 1)
            return 32'hffff_ffff;
        else
            return $urandom;
    endfunction

    function automatic logic [27:0] pick_payload_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 28'd0;
        else if (r == 1)
            return 28'hfff_ffff;
        else
            return 28'($urandom);
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [31:0] elem_id,
                                input logic [31:0] value, input logic [27:0] payload_len);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, payload_len, value, elem_id};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int run;
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120)
                                                  : $urandom_range(1, 12);
                repeat (run) @(posedge i_clk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_UINT8;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Length boundaries of the ID, narrow values with high bits set, and
        // fields that the request kind ignores carrying nonzero data.
        send_request(REQ_UINT8,  32'd0,          32'd0,          28'd0);
        send_request(REQ_UINT8,  32'd126,        32'hffff_ff5a,  28'hfff_ffff);
        send_request(REQ_UINT16, 32'd127,        32'hdead_beef,  28'd0);
        send_request(REQ_UINT16, 32'd16382,      32'h0000_ffff,  28'h555_5555);
        send_request(REQ_UINT32, 32'd16383,      32'hffff_ffff,  28'd0);
        send_request(REQ_UINT32, 32'h001f_fffe,  32'd0,          28'hfff_ffff);
        send_request(REQ_DATA,   32'h001f_ffff,  32'hffff_ffff,  28'd0);
        send_request(REQ_DATA,   32'h0fff_fffe,  32'd0,          28'hfff_ffff);
        send_request(REQ_DATA,   32'h0fff_ffff,  32'h1234_5678,  28'h123_4567);
        send_request(REQ_UINT8,  32'hffff_ffff,  32'h0000_00a5,  28'd0);
        send_request(REQ_UINT16, 32'h8000_0000,  32'h0000_8001,  28'd1);
        send_request(REQ_UINT32, 32'hffff_fffe,  32'h8000_0001,  28'd0);
        send_request(REQ_DATA,   32'd0,          32'd0,          28'h800_0000);
        send_request(REQ_DATA,   32'hffff_ffff,  32'hffff_ffff,  28'hfff_ffff);
        send_request(REQ_UINT32, 32'd126,        32'h5555_aaaa,  28'haaa_aaaa);
        send_request(REQ_UINT8,  32'h0000_3fff,  32'hffff_ffff,  28'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Alternate stretches with and without input gaps; in the middle,
            // push back-to-back requests against a long output hold-off.
            if (i == 150) begin
                hold_off_req = 1'b1;
                sender_idles = 1'b0;
            end else if (i == 200) begin
                sender_idles = 1'b1;
            end else if (i % 60 == 30) begin
                sender_idles = !sender_idles;
            end
            send_request(2'($urandom_range(0, 3)), pick_elem_id(), pick_value(),
                         pick_payload_len());
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Encoded %0d element requests into %0d bytes across all four kinds.",
                 requests, bytes_seen);
        $display("IDs of one to five bytes were hit at their edges, with a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
